// ===== sv/cffa_pkg.sv =====
package cffa_pkg;

   localparam int MAX_FILES_DEFAULT  = 32;
   localparam int MAX_BLOCKS_DEFAULT = 1024;
   localparam int NAME_BYTES_DEFAULT = 8;

   localparam int NAME_W   = 64;
   localparam int COUNT_W  = 11;
   localparam int OWNER_W  = 16;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;
   localparam int CSR_W    = 32;

   localparam logic [COUNT_W-1:0] DISK_SIZE_RESET = 11'd1024;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOPERM   = 2'd3;

   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [0:0] REG_DISK_SIZE = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DEL_RD,
      S_DEL_CHK,
      S_RESP
   } state_type;

endpackage

// ===== sv/cffa_ram.sv =====
module cffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/cffa_ctrl.sv =====
module cffa_ctrl #(
   parameter int MAX_FILES  = cffa_pkg::MAX_FILES_DEFAULT,
   parameter int MAX_BLOCKS = cffa_pkg::MAX_BLOCKS_DEFAULT,
   parameter int NAME_BYTES = cffa_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cffa_pkg::COUNT_W-1:0]    disk_size,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [cffa_pkg::NAME_W-1:0]     req_file_name,
   input  logic [cffa_pkg::COUNT_W-1:0]    req_block_count,
   input  logic signed [cffa_pkg::OWNER_W-1:0] req_owner_id,
   input  logic                            req_is_realtime,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cffa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cffa_pkg::START_W-1:0]    rsp_start_block
);

   localparam int FW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int BW = $clog2(MAX_BLOCKS + 1);
   localparam int EW = cffa_pkg::NAME_W + BW + BW + cffa_pkg::OWNER_W;
   localparam logic [cffa_pkg::NAME_W-1:0] NAME_MASK =
      {cffa_pkg::NAME_W{1'b1}} >> (cffa_pkg::NAME_W - 8 * NAME_BYTES);

   cffa_pkg::state_type state_ff, state_in;
   logic [MAX_FILES-1:0] used_ff, used_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [BW-1:0] blk_ff, blk_in, run_ff, run_in, limit_ff, limit_in;
   logic [BW-1:0] cnt_ff, cnt_in;
   logic [cffa_pkg::NAME_W-1:0] name_ff, name_in;
   logic [cffa_pkg::OWNER_W-1:0] own_ff, own_in;
   logic rt_ff, rt_in, taken_ff, taken_in;
   logic [cffa_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [cffa_pkg::START_W-1:0] sb_ff, sb_in;

   logic wr_en;
   logic [FW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [cffa_pkg::NAME_W-1:0] rd_name;
   logic [BW-1:0] rd_start, rd_len;
   logic [cffa_pkg::OWNER_W-1:0] rd_owner;
   logic [BW:0] rd_end;
   logic hit;
   logic free_found;
   logic [FW-1:0] free_idx;
   logic [BW-1:0] lim_sat, first;

   function automatic logic [cffa_pkg::COUNT_W-1:0] COUNT_MAX();
      return (BW >= cffa_pkg::COUNT_W) ? '1 : cffa_pkg::COUNT_W'((1 << BW) - 1);
   endfunction

   function automatic logic [cffa_pkg::COUNT_W:0] COUNT_W_LIM(input logic [BW-1:0] v);
      return (cffa_pkg::COUNT_W + 1)'(v);
   endfunction

   assign {rd_name, rd_start, rd_len, rd_owner} = rd_data;
   assign rd_end = {1'b0, rd_start} + {1'b0, rd_len};
   assign hit = used_ff[idx_ff] && ({1'b0, blk_ff} >= {1'b0, rd_start})
                && ({1'b0, blk_ff} < rd_end);
   assign first = blk_ff + BW'(1) - cnt_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int f = MAX_FILES - 1; f >= 0; f--) begin
         if (!used_ff[f]) begin
            free_found = 1'b1;
            free_idx   = FW'(f);
         end
      end
      if ({1'b0, disk_size} > (BW + 1)'(MAX_BLOCKS)) begin
         lim_sat = BW'(MAX_BLOCKS);
      end else begin
         lim_sat = BW'(disk_size);
      end
   end

   cffa_ram #(.WIDTH(EW), .DEPTH(MAX_FILES)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cffa_pkg::S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
      idx_ff   <= idx_in;
      blk_ff   <= blk_in;
      run_ff   <= run_in;
      limit_ff <= limit_in;
      cnt_ff   <= cnt_in;
      name_ff  <= name_in;
      own_ff   <= own_in;
      rt_ff    <= rt_in;
      taken_ff <= taken_in;
      st_ff    <= st_in;
      sb_ff    <= sb_in;
   end

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      idx_in   = idx_ff;
      blk_in   = blk_ff;
      run_in   = run_ff;
      limit_in = limit_ff;
      cnt_in   = cnt_ff;
      name_in  = name_ff;
      own_in   = own_ff;
      rt_in    = rt_ff;
      taken_in = taken_ff;
      st_in    = st_ff;
      sb_in    = sb_ff;
      wr_en    = 1'b0;
      wr_addr  = free_idx;
      wr_data  = {name_ff, blk_ff + BW'(1) - cnt_ff, cnt_ff, own_ff};
      req_ready = (state_ff == cffa_pkg::S_IDLE);
      rsp_valid = (state_ff == cffa_pkg::S_RESP);
      case (state_ff)
         cffa_pkg::S_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               name_in  = req_file_name & NAME_MASK;
               cnt_in   = (req_block_count > COUNT_MAX()) ? '1 : BW'(req_block_count);
               own_in   = req_owner_id;
               rt_in    = req_is_realtime;
               limit_in = lim_sat;
               blk_in   = '0;
               run_in   = '0;
               taken_in = 1'b0;
               sb_in    = '0;
               if (req_operation == cffa_pkg::OP_CREATE) begin
                  st_in = cffa_pkg::ST_NOSPACE;
                  if (req_block_count == '0 || lim_sat == '0
                      || {1'b0, req_block_count} > {1'b0, COUNT_W_LIM(lim_sat)}) begin
                     state_in = cffa_pkg::S_RESP;
                  end else begin
                     state_in = cffa_pkg::S_SCAN_RD;
                  end
               end else begin
                  st_in    = cffa_pkg::ST_NOTFOUND;
                  state_in = cffa_pkg::S_DEL_RD;
               end
            end
         end
         cffa_pkg::S_SCAN_RD: begin
            state_in = cffa_pkg::S_SCAN_CHK;
         end
         cffa_pkg::S_SCAN_CHK: begin
            if (hit) begin
               taken_in = 1'b1;
            end
            if (idx_ff != FW'(MAX_FILES - 1) && !hit) begin
               idx_in   = idx_ff + FW'(1);
               state_in = cffa_pkg::S_SCAN_RD;
            end else begin
               idx_in   = '0;
               taken_in = 1'b0;
               if (hit || taken_ff) begin
                  run_in = '0;
               end else begin
                  run_in = run_ff + BW'(1);
               end
               if (!(hit || taken_ff) && run_ff + BW'(1) == cnt_ff) begin
                  state_in = cffa_pkg::S_RESP;
                  if (free_found) begin
                     wr_en            = 1'b1;
                     used_in[free_idx] = 1'b1;
                     st_in            = cffa_pkg::ST_OK;
                     sb_in            = cffa_pkg::START_W'(first);
                  end
               end else if (blk_ff + BW'(1) >= limit_ff) begin
                  state_in = cffa_pkg::S_RESP;
               end else begin
                  blk_in   = blk_ff + BW'(1);
                  state_in = cffa_pkg::S_SCAN_RD;
               end
            end
         end
         cffa_pkg::S_DEL_RD: begin
            state_in = cffa_pkg::S_DEL_CHK;
         end
         cffa_pkg::S_DEL_CHK: begin
            if (used_ff[idx_ff] && rd_name == name_ff) begin
               state_in = cffa_pkg::S_RESP;
               if (rt_ff || rd_owner == own_ff) begin
                  used_in[idx_ff] = 1'b0;
                  st_in = cffa_pkg::ST_OK;
               end else begin
                  st_in = cffa_pkg::ST_NOPERM;
               end
            end else if (idx_ff == FW'(MAX_FILES - 1)) begin
               state_in = cffa_pkg::S_RESP;
            end else begin
               idx_in   = idx_ff + FW'(1);
               state_in = cffa_pkg::S_DEL_RD;
            end
         end
         cffa_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = cffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cffa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_status      = st_ff;
   assign rsp_start_block = sb_ff;

endmodule

// ===== sv/contiguous_first_fit_file_allocator.sv =====
// Create: each block below disk_size (capped at MAX_BLOCKS) is checked against the
// entries one at a time, with a read state and a check state per entry.
// Delete: the entries are read one slot at a time, a read state and a check state per slot.
// One request at a time; the result is held until taken, then the next is accepted.
// Synchronous active-high reset clears the used bits and sets disk_size to 1024.
module contiguous_first_fit_file_allocator #(
   parameter int MAX_FILES  = cffa_pkg::MAX_FILES_DEFAULT,
   parameter int MAX_BLOCKS = cffa_pkg::MAX_BLOCKS_DEFAULT,
   parameter int NAME_BYTES = cffa_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [cffa_pkg::NAME_W-1:0]     req_file_name,
   input  logic [cffa_pkg::COUNT_W-1:0]    req_block_count,
   input  logic signed [cffa_pkg::OWNER_W-1:0] req_owner_id,
   input  logic                            req_is_realtime,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cffa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cffa_pkg::START_W-1:0]    rsp_start_block,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [cffa_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [cffa_pkg::CSR_W-1:0]      csr_prdata,
   output logic                            csr_pready
);

   logic [cffa_pkg::COUNT_W-1:0] disk_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_size_ff <= cffa_pkg::DISK_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == cffa_pkg::REG_DISK_SIZE && csr_paddr[1:0] == 2'b00) begin
         disk_size_ff <= csr_pwdata[cffa_pkg::COUNT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == cffa_pkg::REG_DISK_SIZE)
                       ? {{(cffa_pkg::CSR_W - cffa_pkg::COUNT_W){1'b0}}, disk_size_ff} : '0;

   cffa_ctrl #(
      .MAX_FILES  (MAX_FILES),
      .MAX_BLOCKS (MAX_BLOCKS),
      .NAME_BYTES (NAME_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .disk_size       (disk_size_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_file_name   (req_file_name),
      .req_block_count (req_block_count),
      .req_owner_id    (req_owner_id),
      .req_is_realtime (req_is_realtime),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_start_block (rsp_start_block)
   );

endmodule

// ===== sv/cffa_checker.sv =====
module cffa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cffa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [cffa_pkg::START_W-1:0]     rsp_start_block
);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_start_block)) else $error("result changed while stalled");

   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cffa_pkg::ST_OK |-> rsp_start_block == '0)
      else $error("start block on failure");

   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result after reset");

endmodule

bind contiguous_first_fit_file_allocator cffa_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_start_block (rsp_start_block)
);

// ===== tb/contiguous_first_fit_file_allocator_tb.sv =====
module contiguous_first_fit_file_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SLOTS   = 32;
   localparam int N_BLOCKS  = 1024;
   localparam longint LIMIT = 200_000_000;

   typedef struct packed {
      logic [cffa_pkg::STATUS_W-1:0] status;
      logic [cffa_pkg::START_W-1:0]  start;
   } outcome_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_operation;
   logic [cffa_pkg::NAME_W-1:0] req_file_name;
   logic [cffa_pkg::COUNT_W-1:0] req_block_count;
   logic signed [cffa_pkg::OWNER_W-1:0] req_owner_id;
   logic req_is_realtime;
   logic rsp_valid;
   logic rsp_ready;
   logic [cffa_pkg::STATUS_W-1:0] rsp_status;
   logic [cffa_pkg::START_W-1:0] rsp_start_block;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [cffa_pkg::CSR_W-1:0] csr_pwdata;
   logic [cffa_pkg::CSR_W-1:0] csr_prdata;
   logic csr_pready;

   contiguous_first_fit_file_allocator u_dut (.*);

   outcome_type outcome_q[$];
   int errors;
   longint cycles;
   bit calm;

   logic [cffa_pkg::COUNT_W-1:0] disk_blocks;
   bit slot_used[N_SLOTS];
   logic [cffa_pkg::NAME_W-1:0] slot_name[N_SLOTS];
   int slot_start[N_SLOTS];
   int slot_len[N_SLOTS];
   logic [cffa_pkg::OWNER_W-1:0] slot_owner[N_SLOTS];
   logic [cffa_pkg::NAME_W-1:0] name_pool[8];

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 20);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status %0d start %0d",
                     $time, rsp_status, rsp_start_block);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_start_block !== want.start) begin
               errors++;
               $display("%0t: start_block expected %0d actual %0d",
                        $time, want.start, rsp_start_block);
            end
         end
      end
   end

   function automatic bit block_busy(int b);
      for (int f = 0; f < N_SLOTS; f++)
         if (slot_used[f] && b >= slot_start[f] && b < slot_start[f] + slot_len[f])
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic outcome_type allocate_or_free(logic op,
                                                    logic [cffa_pkg::NAME_W-1:0] name,
                                                    logic [cffa_pkg::COUNT_W-1:0] count,
                                                    logic [cffa_pkg::OWNER_W-1:0] owner,
                                                    logic rt);
      outcome_type res;
      int span;
      int run;
      int first;
      bit found;
      res.status = cffa_pkg::ST_NOSPACE;
      res.start = '0;
      found = 1'b0;
      first = 0;
      run = 0;
      if (op == cffa_pkg::OP_CREATE) begin
         span = (disk_blocks > N_BLOCKS) ? N_BLOCKS : int'(disk_blocks);
         if (count != 0) begin
            for (int b = 0; b < span && !found; b++) begin
               if (block_busy(b)) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == int'(count)) begin
                     first = b + 1 - int'(count);
                     found = 1'b1;
                  end
               end
            end
         end
         if (found) begin
            for (int f = 0; f < N_SLOTS; f++) begin
               if (!slot_used[f]) begin
                  slot_used[f] = 1'b1;
                  slot_name[f] = name;
                  slot_start[f] = first;
                  slot_len[f] = int'(count);
                  slot_owner[f] = owner;
                  res.status = cffa_pkg::ST_OK;
                  res.start = first[cffa_pkg::START_W-1:0];
                  break;
               end
            end
         end
      end else begin
         res.status = cffa_pkg::ST_NOTFOUND;
         for (int f = 0; f < N_SLOTS; f++) begin
            if (slot_used[f] && slot_name[f] == name) begin
               if (rt || slot_owner[f] == owner) begin
                  slot_used[f] = 1'b0;
                  res.status = cffa_pkg::ST_OK;
               end else begin
                  res.status = cffa_pkg::ST_NOPERM;
               end
               break;
            end
         end
      end
      return res;
   endfunction

   task automatic send_request(logic op, logic [cffa_pkg::NAME_W-1:0] name,
                               logic [cffa_pkg::COUNT_W-1:0] count,
                               logic [cffa_pkg::OWNER_W-1:0] owner, logic rt);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_file_name <= name;
      req_block_count <= count;
      req_owner_id <= owner;
      req_is_realtime <= rt;
      do @(posedge clock); while (!req_ready);
      outcome_q.push_back(allocate_or_free(op, name, count, owner, rt));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] addr, logic [cffa_pkg::CSR_W-1:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == {cffa_pkg::REG_DISK_SIZE, 2'b00})
         disk_blocks = value[cffa_pkg::COUNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic test_extremes;
      send_request(cffa_pkg::OP_CREATE, 64'h0, 11'd0, 16'h0, 1'b0);
      send_request(cffa_pkg::OP_CREATE, 64'h1, 11'd1025, 16'h0, 1'b0);
      send_request(cffa_pkg::OP_CREATE, '1, 11'd1024, 16'hFFFF, 1'b0);
      send_request(cffa_pkg::OP_CREATE, 64'h2, 11'd1, 16'h7FFF, 1'b0);
      send_request(cffa_pkg::OP_DELETE, '1, 11'd0, 16'h7FFF, 1'b0);
      send_request(cffa_pkg::OP_DELETE, '1, 11'd2047, 16'h7FFF, 1'b1);
      send_request(cffa_pkg::OP_DELETE, '1, 11'd0, 16'hFFFF, 1'b0);
      send_request(cffa_pkg::OP_CREATE, 64'h3, 11'd2047, 16'h8000, 1'b1);
   endtask

   task automatic test_disk_sizes;
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'd0);
      send_request(cffa_pkg::OP_CREATE, 64'h10, 11'd1, 16'h1, 1'b0);
      write_register(3'd4, 32'd5);
      send_request(cffa_pkg::OP_CREATE, 64'h11, 11'd1, 16'h1, 1'b0);
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'hFFFF_FFFF);
      send_request(cffa_pkg::OP_CREATE, 64'h12, 11'd1024, 16'h5, 1'b0);
      send_request(cffa_pkg::OP_DELETE, 64'h12, 11'd0, 16'h5, 1'b0);
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'd1);
      send_request(cffa_pkg::OP_CREATE, 64'h13, 11'd1, 16'h2, 1'b0);
      send_request(cffa_pkg::OP_CREATE, 64'h14, 11'd1, 16'h2, 1'b0);
      send_request(cffa_pkg::OP_DELETE, 64'h13, 11'd0, 16'h2, 1'b0);
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'd16);
      send_request(cffa_pkg::OP_CREATE, 64'hAA, 11'd12, 16'h3, 1'b0);
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'd4);
      send_request(cffa_pkg::OP_CREATE, 64'hBB, 11'd1, 16'h3, 1'b0);
      send_request(cffa_pkg::OP_DELETE, 64'hAA, 11'd0, 16'h3, 1'b0);
      send_request(cffa_pkg::OP_CREATE, 64'hBB, 11'd4, 16'h3, 1'b0);
      send_request(cffa_pkg::OP_DELETE, 64'hBB, 11'd0, 16'h4, 1'b1);
   endtask

   task automatic test_table_full;
      write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, 32'd40);
      for (int i = 0; i <= N_SLOTS; i++)
         send_request(cffa_pkg::OP_CREATE, 64'h100 + i, 11'd1, 16'h9, 1'b0);
      for (int i = 0; i < N_SLOTS; i++)
         send_request(cffa_pkg::OP_DELETE, 64'h100 + i, 11'd0, 16'h0, 1'b1);
   endtask

   function automatic logic [cffa_pkg::OWNER_W-1:0] pick_owner;
      case ($urandom_range(0, 5))
         0: return 16'h0;
         1: return 16'h1;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         4: return 16'h2;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_request;
      int r;
      logic [cffa_pkg::COUNT_W-1:0] count;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         case ($urandom_range(0, 9))
            0: count = 11'd0;
            1: count = 11'($urandom_range(0, 2047));
            default: count = 11'($urandom_range(1, 6));
         endcase
         send_request(cffa_pkg::OP_CREATE, name_pool[3'($urandom_range(0, 7))], count,
                      pick_owner(), $urandom_range(0, 9) == 0);
      end else if (r < 90) begin
         send_request(cffa_pkg::OP_DELETE, name_pool[3'($urandom_range(0, 7))],
                      11'($urandom), pick_owner(), $urandom_range(0, 4) == 0);
      end else begin
         send_request(1'($urandom), {$urandom, $urandom}, 11'($urandom_range(0, 12)),
                      16'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_random;
      int sizes[6] = '{8, 24, 16, 32, 3, 40};
      for (int p = 0; p < 6; p++) begin
         write_register({cffa_pkg::REG_DISK_SIZE, 2'b00}, sizes[p]);
         calm = (p == 2);
         for (int i = 0; i < 80; i++) begin
            if (i == 40 && p == 4)
               drain();
            random_request();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      calm = 1'b0;
      disk_blocks = cffa_pkg::DISK_SIZE_RESET;
      for (int f = 0; f < N_SLOTS; f++)
         slot_used[f] = 1'b0;
      for (int i = 0; i < 8; i++)
         name_pool[i] = {$urandom, $urandom};
      name_pool[0] = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = cffa_pkg::OP_CREATE;
      req_file_name = '0;
      req_block_count = '0;
      req_owner_id = '0;
      req_is_realtime = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_disk_sizes();
      test_table_full();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
